// ===== hdl/mams_pkg.sv =====
`default_nettype none

package mams_pkg;

  localparam int ID_W      = 16;
  localparam int KEY_LIMBS = 6;
  localparam int CNT_W     = 4;
  localparam int SH_W      = 3;

  localparam logic [CNT_W-1:0] DOT_OPS = CNT_W'(3);
  localparam logic [CNT_W-1:0] SQ_OPS  = CNT_W'(4);
  localparam logic [CNT_W-1:0] KEY_OPS = CNT_W'(8);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_MSQ,
    ST_SQ,
    ST_KA,
    ST_KB,
    ST_FIN
  } seq_state_t;

  typedef struct packed {
    logic            vld;
    logic            clr;
    logic [SH_W-1:0] sh;
  } mac_ctl_t;

  // number of limb products issued in each phase
  function automatic logic [CNT_W-1:0] phase_len(seq_state_t s);
    case (s)
      ST_DOT, ST_MSQ: return DOT_OPS;
      ST_SQ:          return SQ_OPS;
      ST_KA, ST_KB:   return KEY_OPS;
      default:        return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mams_mac.sv =====
`default_nettype none

module mams_mac #(
  parameter int LIMB_W = 17
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mams_pkg::mac_ctl_t                    ctl,
  input  logic [LIMB_W-1:0]                     op_a,
  input  logic [LIMB_W-1:0]                     op_b,
  output logic [mams_pkg::KEY_LIMBS*LIMB_W-1:0] acc
);
  import mams_pkg::*;

  localparam int PROD_W = 2 * LIMB_W;
  localparam int ACC_W  = KEY_LIMBS * LIMB_W;

  mac_ctl_t            ctl_r;
  logic [PROD_W-1:0]   prod_r;
  logic [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]    sh_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  // place the product at its limb position
  always_comb begin
    case (ctl_r.sh)
      SH_W'(0): sh_prod = ACC_W'(prod_r);
      SH_W'(1): sh_prod = ACC_W'(prod_r) << LIMB_W;
      SH_W'(2): sh_prod = ACC_W'(prod_r) << (2 * LIMB_W);
      SH_W'(3): sh_prod = ACC_W'(prod_r) << (3 * LIMB_W);
      SH_W'(4): sh_prod = ACC_W'(prod_r) << (4 * LIMB_W);
      default:  sh_prod = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl_r.vld) begin
      acc_r <= (ctl_r.clr ? '0 : acc_r) + sh_prod;
    end
  end

  assign acc = acc_r;

  a_clr_with_vld: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |-> ctl.vld)
    else $error("mac clear without a product");

  a_sh_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld |-> (ctl.sh <= SH_W'(4)))
    else $error("mac shift beyond key width");

  a_clr_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.vld && ctl_r.clr |=> acc_r == $past(sh_prod))
    else $error("mac clear did not restart accumulation");

endmodule

`default_nettype wire

// ===== hdl/min_angle_machine_select_core.sv =====
`default_nettype none
// A candidate with a zero vector skips the multiplier; the first valid candidate of a run
//   forms the dot product, norm and dot square, and each later one also both cross keys.
// The result word is registered when the last item of a run ends and the output is not stalled.
// A single limb multiplier forms every limb product; no new item is taken until the last is done.
// Reset: synchronous active-low rst_n clears the sequencer, the run state and the output valid flag.

module min_angle_machine_select_core #(
  parameter int RES_BITS   = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [RES_BITS-1:0]       in_machine_cpu,
  input  logic [RES_BITS-1:0]       in_machine_mem,
  input  logic [RES_BITS-1:0]       in_machine_disk,
  input  logic [mams_pkg::ID_W-1:0] in_machine_id,
  input  logic [RES_BITS-1:0]       in_task_cpu,
  input  logic [RES_BITS-1:0]       in_task_mem,
  input  logic [RES_BITS-1:0]       in_task_disk,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mams_pkg::ID_W-1:0] out_best_id,
  output logic                      out_found
);
  import mams_pkg::*;

  localparam int LIMB_W = RES_BITS + 1;
  localparam int NORM_W = 2 * LIMB_W;
  localparam int SQ_W   = 4 * LIMB_W;
  localparam int ACC_W  = KEY_LIMBS * LIMB_W;
  localparam logic [ID_W-1:0] ID_MASK =
    (INDEX_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((64'd1 << INDEX_BITS) - 64'd1);

  seq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  len;
  logic              in_accept, skip, cap, take, emit;

  logic [RES_BITS-1:0] m_r [3];
  logic [RES_BITS-1:0] t_r [3];
  logic [ID_W-1:0]     id_r;
  logic                last_r;

  logic [NORM_W-1:0]   dot_r, msq_r, best_norm_r;
  logic [SQ_W-1:0]     sq_r, best_sq_r;
  logic [ACC_W-1:0]    ka_r;
  logic                have_best_r;
  logic [ID_W-1:0]     best_id_r;

  logic                out_valid_r, out_found_r;
  logic [ID_W-1:0]     out_best_id_r;

  mac_ctl_t            mac_ctl;
  logic [LIMB_W-1:0]   op_a, op_b;
  logic [ACC_W-1:0]    acc;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign skip      = ((in_machine_cpu | in_machine_mem | in_machine_disk) == '0) ||
                     ((in_task_cpu | in_task_mem | in_task_disk) == '0);

  assign len  = phase_len(state_r);
  assign cap  = (len != '0) && (cnt_r == len + CNT_W'(1));
  assign take = cap && (((state_r == ST_SQ) && !have_best_r) ||
                        ((state_r == ST_KB) && (ka_r > acc)));
  assign emit = (state_r == ST_FIN) && last_r && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = skip ? ST_FIN : ST_DOT;
        end
      end
      ST_DOT: if (cap) state_nxt = ST_MSQ;
      ST_MSQ: if (cap) state_nxt = ST_SQ;
      ST_SQ:  if (cap) state_nxt = have_best_r ? ST_KA : ST_FIN;
      ST_KA:  if (cap) state_nxt = ST_KB;
      ST_KB:  if (cap) state_nxt = ST_FIN;
      ST_FIN: begin
        if (!last_r || !out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = '0;
    if (len != '0 && !cap) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // limb operand selection for the shared multiplier
  always_comb begin
    logic [1:0] ki;
    logic       kj;
    ki      = cnt_r[2:1];
    kj      = cnt_r[0];
    mac_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    if (cnt_r < len) begin
      mac_ctl.vld = 1'b1;
      mac_ctl.clr = (cnt_r == '0);
      case (state_r)
        ST_DOT: begin
          op_a = LIMB_W'(m_r[cnt_r[1:0]]);
          op_b = LIMB_W'(t_r[cnt_r[1:0]]);
        end
        ST_MSQ: begin
          op_a = LIMB_W'(m_r[cnt_r[1:0]]);
          op_b = LIMB_W'(m_r[cnt_r[1:0]]);
        end
        ST_SQ: begin
          op_a       = dot_r[cnt_r[1]*LIMB_W +: LIMB_W];
          op_b       = dot_r[cnt_r[0]*LIMB_W +: LIMB_W];
          mac_ctl.sh = SH_W'(cnt_r[1]) + SH_W'(cnt_r[0]);
        end
        ST_KA: begin
          op_a       = sq_r[ki*LIMB_W +: LIMB_W];
          op_b       = best_norm_r[kj*LIMB_W +: LIMB_W];
          mac_ctl.sh = SH_W'(ki) + SH_W'(kj);
        end
        ST_KB: begin
          op_a       = best_sq_r[ki*LIMB_W +: LIMB_W];
          op_b       = msq_r[kj*LIMB_W +: LIMB_W];
          mac_ctl.sh = SH_W'(ki) + SH_W'(kj);
        end
        default: mac_ctl = '0;
      endcase
    end
  end

  mams_mac #(
    .LIMB_W (LIMB_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        have_best_r <= 1'b0;
      end else if (take) begin
        have_best_r <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_r[0] <= in_machine_cpu;
      m_r[1] <= in_machine_mem;
      m_r[2] <= in_machine_disk;
      t_r[0] <= in_task_cpu;
      t_r[1] <= in_task_mem;
      t_r[2] <= in_task_disk;
      id_r   <= in_machine_id & ID_MASK;
      last_r <= in_last;
    end
    if (cap && state_r == ST_DOT) dot_r <= acc[NORM_W-1:0];
    if (cap && state_r == ST_MSQ) msq_r <= acc[NORM_W-1:0];
    if (cap && state_r == ST_SQ)  sq_r  <= acc[SQ_W-1:0];
    if (cap && state_r == ST_KA)  ka_r  <= acc;
    if (take) begin
      best_sq_r   <= (state_r == ST_SQ) ? acc[SQ_W-1:0] : sq_r;
      best_norm_r <= msq_r;
      best_id_r   <= id_r;
    end
    if (emit) begin
      out_best_id_r <= have_best_r ? best_id_r : '0;
      out_found_r   <= have_best_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_best_id = out_best_id_r;
  assign out_found   = out_found_r;

  a_keys_need_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KA || state_r == ST_KB) |-> have_best_r)
    else $error("cross key computed with no best candidate");

  a_empty_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_best_id == '0)
    else $error("empty run reported a machine id");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> !have_best_r && out_valid_r)
    else $error("run end did not clear the best candidate");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_DOT || state_r == ST_FIN))
    else $error("accepted word did not start work");

endmodule

`default_nettype wire
